FILE: src/gnntt_pkg.sv
// Shared types and constants of the gated nearest-neighbor track table.
package gnntt_pkg;

   localparam int CoordW = 24;
   localparam int TimeW  = 48;
   localparam int MissW  = 17;
   localparam int SqW    = 49;
   localparam int NumW   = 49;

   localparam logic [MissW-1:0]  MISS_MAX   = 17'h1FFFF;
   localparam logic [19:0]       US_PER_S   = 20'd1000000;
   localparam logic [31:0]       RECIP_TEN  = 32'hCCCCCCCD;
   localparam logic [NumW-1:0]   INST_LIM   = 49'h0000040000000;
   localparam logic [28:0]       VEL_POS_LIM = 29'd8388607;
   localparam logic [28:0]       VEL_NEG_LIM = 29'd8388608;
   localparam logic [CoordW-1:0] VEL_MAX    = 24'h7FFFFF;
   localparam logic [CoordW-1:0] VEL_MIN    = 24'h800000;
   localparam logic [19:0]       GATE_RESET  = 20'd2000;
   localparam logic [15:0]       LIMIT_RESET = 16'd5;

   typedef enum logic [1:0] {
      OP_FRAME_BEGIN = 2'd0,
      OP_DETECT      = 2'd1,
      OP_FRAME_END   = 2'd2,
      OP_UNUSED      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_UPDATED = 2'd0,
      ST_BORN    = 2'd1,
      ST_FULL    = 2'd2,
      ST_UNUSED  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_GATE   = 2'd0,
      REG_LIMIT  = 2'd1,
      REG_ENABLE = 2'd2,
      REG_NONE   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [31:0]             id;
      logic [7:0]              cls;
      logic [2:0][CoordW-1:0]  pos;
      logic [2:0][CoordW-1:0]  vel;
      logic [15:0]             conf;
      logic [MissW-1:0]        missed;
      logic [TimeW-1:0]        last;
   } rec_type;

   typedef struct packed {
      logic [31:0]             track_id;
      logic [7:0]              cls;
      logic [2:0][CoordW-1:0]  pos;
      logic [2:0][CoordW-1:0]  vel;
      logic [15:0]             conf;
      logic [TimeW-1:0]        stamp;
      logic [1:0]              status;
   } res_type;

   typedef struct packed {
      logic take;
      logic sweep;
      logic scan;
      logic fetch;
      logic diff;
      logic mul;
      logic div_go;
      logic mix;
      logic recip;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic go_sweep;
      logic go_scan;
      logic sweep_done;
      logic scan_done;
      logic found;
      logic div_done;
      logic out_free;
   } stat_type;

endpackage

FILE: src/gnntt_req_if.sv
// Input channel of the track table: one beat per frame marker or detection.
interface gnntt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [7:0]  object_class;
   logic [23:0] pos_x;
   logic [23:0] pos_y;
   logic [23:0] pos_z;
   logic [23:0] det_vel_x;
   logic [23:0] det_vel_y;
   logic [23:0] det_vel_z;
   logic [15:0] confidence;
   logic [47:0] frame_time_us;

   modport source (output valid, op, object_class, pos_x, pos_y, pos_z,
                   det_vel_x, det_vel_y, det_vel_z, confidence, frame_time_us,
                   input ready);
   modport sink (input valid, op, object_class, pos_x, pos_y, pos_z,
                 det_vel_x, det_vel_y, det_vel_z, confidence, frame_time_us,
                 output ready);
endinterface

FILE: src/gnntt_rsp_if.sv
// Result channel of the track table: one beat per processed detection.
interface gnntt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] track_id;
   logic [7:0]  object_class_res;
   logic [23:0] pos_x_res;
   logic [23:0] pos_y_res;
   logic [23:0] pos_z_res;
   logic [23:0] vel_x;
   logic [23:0] vel_y;
   logic [23:0] vel_z;
   logic [15:0] confidence_res;
   logic [47:0] stamp_us;
   logic [1:0]  status;

   modport source (output valid, track_id, object_class_res, pos_x_res, pos_y_res,
                   pos_z_res, vel_x, vel_y, vel_z, confidence_res, stamp_us, status,
                   input ready);
   modport sink (input valid, track_id, object_class_res, pos_x_res, pos_y_res,
                 pos_z_res, vel_x, vel_y, vel_z, confidence_res, stamp_us, status,
                 output ready);
endinterface

FILE: src/gnntt_div.sv
// Restoring divider, one quotient bit per cycle.
module gnntt_div #(
   parameter int NumW = 49,
   parameter int DenW = 48
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [NumW-1:0] num,
   input  logic [DenW-1:0] den,
   output logic            done,
   output logic [NumW-1:0] quot
);
   localparam int CntW = $clog2(NumW + 1);

   logic [DenW:0]   rem_ff;
   logic [NumW-1:0] quo_ff;
   logic [DenW-1:0] den_ff;
   logic [CntW-1:0] cnt_ff;
   logic            busy_ff;
   logic            done_ff;
   logic [DenW:0]   shifted;
   logic            ge;
   logic [DenW:0]   diff;

   assign shifted = {rem_ff[DenW-1:0], quo_ff[NumW-1]};
   assign ge      = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CntW'(NumW - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff : shifted;
         quo_ff <= {quo_ff[NumW-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;
endmodule

FILE: src/gnntt_dp.sv
// Datapath: registers, slot memory, scan pipeline, velocity arithmetic and result register.
module gnntt_dp #(
   parameter int MAX_TRACKS = 64
) (
   input  logic                clock,
   input  logic                reset,
   gnntt_req_if.sink           req_ch,
   gnntt_rsp_if.source         rsp_ch,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   input  gnntt_pkg::cmd_type  cmd,
   output gnntt_pkg::stat_type stat
);
   localparam int IW = $clog2(MAX_TRACKS);
   localparam int CW = $clog2(MAX_TRACKS + 1);

   // Configuration registers.
   logic [19:0] gate_ff;
   logic [15:0] limit_ff;
   logic        enable_ff;
   logic        csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff   <= gnntt_pkg::GATE_RESET;
         limit_ff  <= gnntt_pkg::LIMIT_RESET;
         enable_ff <= 1'b0;
      end else if (csr_wr) begin
         case (gnntt_pkg::reg_index_type'(paddr[3:2]))
            gnntt_pkg::REG_GATE:   gate_ff   <= pwdata[19:0];
            gnntt_pkg::REG_LIMIT:  limit_ff  <= pwdata[15:0];
            gnntt_pkg::REG_ENABLE: enable_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (gnntt_pkg::reg_index_type'(paddr[3:2]))
         gnntt_pkg::REG_GATE:   prdata = {12'd0, gate_ff};
         gnntt_pkg::REG_LIMIT:  prdata = {16'd0, limit_ff};
         gnntt_pkg::REG_ENABLE: prdata = {31'd0, enable_ff};
         default:               prdata = '0;
      endcase
   end

   // Input beat capture.
   logic                    acc;
   gnntt_pkg::op_type       op_ff;
   logic [7:0]              cls_ff;
   logic [2:0][23:0]        pos_ff;
   logic [2:0][23:0]        dvel_ff;
   logic [15:0]             conf_ff;
   logic [47:0]             now_ff;
   logic [39:0]             gate2_ff;
   gnntt_pkg::op_type       req_op;

   assign acc          = cmd.take & req_ch.valid;
   assign req_ch.ready = cmd.take;
   assign req_op       = gnntt_pkg::op_type'(req_ch.op);

   always_ff @(posedge clock) begin
      if (acc) begin
         op_ff      <= req_op;
         cls_ff     <= req_ch.object_class;
         pos_ff     <= {req_ch.pos_z, req_ch.pos_y, req_ch.pos_x};
         dvel_ff    <= {req_ch.det_vel_z, req_ch.det_vel_y, req_ch.det_vel_x};
         conf_ff    <= req_ch.confidence;
         now_ff     <= req_ch.frame_time_us;
         gate2_ff   <= gate_ff * gate_ff;
      end
   end

   // Slot memory and valid flags.
   gnntt_pkg::rec_type   mem [MAX_TRACKS];
   gnntt_pkg::rec_type   rd_ff;
   gnntt_pkg::rec_type   wdata;
   logic [IW-1:0]        raddr;
   logic [IW-1:0]        waddr;
   logic                 we;
   logic [MAX_TRACKS-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   // Slot walk shared by the frame sweeps and the detection scan.
   logic [CW-1:0] cnt_ff;
   logic          issue;
   logic          p1_vld_ff;
   logic [IW-1:0] p1_idx_ff;
   logic          p1_live;
   logic [IW-1:0] best_idx_ff;

   assign issue   = (cmd.scan | cmd.sweep) & (cnt_ff != CW'(MAX_TRACKS));
   assign raddr   = cmd.fetch ? best_idx_ff : (issue ? cnt_ff[IW-1:0] : '0);
   assign p1_live = valid_ff[p1_idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         p1_vld_ff <= 1'b0;
      end else begin
         if (acc) begin
            cnt_ff <= '0;
         end else if (issue) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         p1_vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      p1_idx_ff <= cnt_ff[IW-1:0];
   end

   logic sweep_inc;
   logic sweep_drop;

   assign sweep_inc  = cmd.sweep & p1_vld_ff & (op_ff == gnntt_pkg::OP_FRAME_BEGIN) &
                       p1_live & (rd_ff.missed != gnntt_pkg::MISS_MAX);
   assign sweep_drop = cmd.sweep & p1_vld_ff & (op_ff == gnntt_pkg::OP_FRAME_END) &
                       p1_live & (rd_ff.missed > {1'b0, limit_ff});

   // Scan stage one: squared axis distances.
   logic                       p2_vld_ff;
   logic                       p2_hit_ff;
   logic [2:0][gnntt_pkg::SqW-1:0] sq_ff;
   logic [31:0]                p2_id_ff;
   logic [IW-1:0]              p2_idx_ff;
   logic [2:0][gnntt_pkg::SqW-1:0] sq;
   logic signed [24:0]         sd [3];
   logic signed [49:0]         sp [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sd[k] = $signed({pos_ff[k][23], pos_ff[k]}) -
                 $signed({rd_ff.pos[k][23], rd_ff.pos[k]});
         sp[k] = sd[k] * sd[k];
         sq[k] = sp[k][gnntt_pkg::SqW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else begin
         p2_vld_ff <= cmd.scan & p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p2_hit_ff <= p1_live & (rd_ff.cls == cls_ff);
      sq_ff     <= sq;
      p2_id_ff  <= rd_ff.id;
      p2_idx_ff <= p1_idx_ff;
   end

   // The first free slot is noted as the walk passes it.
   logic          free_found_ff;
   logic [IW-1:0] free_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         free_found_ff <= 1'b0;
      end else if (acc) begin
         free_found_ff <= 1'b0;
      end else if (cmd.scan & p1_vld_ff & ~p1_live & ~free_found_ff) begin
         free_found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan & p1_vld_ff & ~p1_live & ~free_found_ff) begin
         free_idx_ff <= p1_idx_ff;
      end
   end

   // Scan stage two: total distance, gate and running best.
   logic [50:0] d2;
   logic [50:0] best_d_ff;
   logic [31:0] best_id_ff;
   logic        found_ff;
   logic        cand;

   assign d2   = 51'(sq_ff[0]) + 51'(sq_ff[1]) + 51'(sq_ff[2]);
   assign cand = p2_vld_ff & p2_hit_ff & (d2 < 51'(gate2_ff)) &
                 (~found_ff | (d2 < best_d_ff) |
                  ((d2 == best_d_ff) & (p2_id_ff < best_id_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (acc) begin
         found_ff <= 1'b0;
      end else if (cand) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cand) begin
         best_d_ff   <= d2;
         best_id_ff  <= p2_id_ff;
         best_idx_ff <= p2_idx_ff;
      end
   end

   // Velocity update of the matched slot.
   gnntt_pkg::rec_type             hold_ff;
   logic [2:0]                     dneg_ff;
   logic [2:0][24:0]               dmag_ff;
   logic [47:0]                    e_ff;
   logic                           skip_ff;
   logic [2:0][gnntt_pkg::NumW-1:0] num_ff;
   logic [2:0][gnntt_pkg::NumW-1:0] quot;
   logic [2:0]                     div_done;
   logic [2:0]                     sneg_ff;
   logic [2:0][31:0]               smag_ff;
   logic [2:0][28:0]               q10_ff;
   logic [2:0][23:0]               dmag_in;
   logic [2:0][31:0]               smag_in;
   logic [2:0][28:0]               q10_in;
   logic [2:0]                     sneg_in;
   logic [2:0][23:0]               vel_new;
   logic signed [24:0]             dd [3];
   logic [24:0]                    dmag_w [3];
   logic [30:0]                    inst_mag [3];
   logic signed [34:0]             vs [3];
   logic signed [34:0]             is [3];
   logic signed [34:0]             sm [3];
   logic [34:0]                    smag_w [3];
   logic [63:0]                    prod [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dd[k] = $signed({pos_ff[k][23], pos_ff[k]}) -
                 $signed({rd_ff.pos[k][23], rd_ff.pos[k]});
         dmag_w[k] = dd[k][24] ? 25'(-dd[k]) : 25'(dd[k]);
         dmag_in[k] = '0;

         inst_mag[k] = (quot[k] > gnntt_pkg::INST_LIM) ? gnntt_pkg::INST_LIM[30:0]
                                                       : quot[k][30:0];
         vs[k] = 35'($signed(hold_ff.vel[k]));
         is[k] = dneg_ff[k] ? -$signed({4'd0, inst_mag[k]}) : $signed({4'd0, inst_mag[k]});
         sm[k] = (vs[k] <<< 3) - vs[k] + (is[k] <<< 1) + is[k];
         smag_w[k] = sm[k][34] ? 35'(-sm[k]) : 35'(sm[k]);
         smag_in[k] = smag_w[k][31:0] + 32'd5;
         sneg_in[k] = sm[k][34];

         prod[k] = 64'(smag_ff[k]) * 64'(gnntt_pkg::RECIP_TEN);
         q10_in[k] = prod[k][63:35];

         if (~sneg_ff[k]) begin
            vel_new[k] = (q10_ff[k] > gnntt_pkg::VEL_POS_LIM) ? gnntt_pkg::VEL_MAX
                                                            : q10_ff[k][23:0];
         end else begin
            vel_new[k] = (q10_ff[k] > gnntt_pkg::VEL_NEG_LIM) ? gnntt_pkg::VEL_MIN
                                                            : 24'(-q10_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         hold_ff <= rd_ff;
         e_ff    <= now_ff - rd_ff.last;
         skip_ff <= now_ff <= rd_ff.last;
         for (int k = 0; k < 3; k++) begin
            dneg_ff[k] <= dd[k][24];
            dmag_ff[k] <= dmag_w[k];
         end
      end
      if (cmd.mul) begin
         for (int k = 0; k < 3; k++) begin
            num_ff[k] <= gnntt_pkg::NumW'(dmag_ff[k] * gnntt_pkg::US_PER_S) +
                         gnntt_pkg::NumW'(e_ff >> 1);
         end
      end
      if (cmd.mix) begin
         smag_ff <= smag_in;
         sneg_ff <= sneg_in;
      end
      if (cmd.recip) begin
         q10_ff <= q10_in;
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_div
      gnntt_div #(
         .NumW(gnntt_pkg::NumW),
         .DenW(48)
      ) u_div (
         .clock (clock),
         .reset (reset),
         .start (cmd.div_go),
         .num   (num_ff[g]),
         .den   (e_ff),
         .done  (div_done[g]),
         .quot  (quot[g])
      );
   end

   // Commit: slot write, valid flags, id counter and result register.
   logic [31:0]         next_id_ff;
   logic [31:0]         next_id_inc;
   logic                commit_wr;
   gnntt_pkg::rec_type  match_rec;
   gnntt_pkg::rec_type  birth_rec;
   gnntt_pkg::rec_type  sweep_rec;
   gnntt_pkg::res_type  res_ff;
   gnntt_pkg::res_type  res_in;
   logic                rsp_valid_ff;

   assign next_id_inc = next_id_ff + 32'd1;
   assign commit_wr   = cmd.commit & (found_ff | free_found_ff);

   always_comb begin
      match_rec        = hold_ff;
      match_rec.pos    = pos_ff;
      match_rec.vel    = skip_ff ? hold_ff.vel : vel_new;
      match_rec.conf   = conf_ff;
      match_rec.missed = '0;
      match_rec.last   = now_ff;

      birth_rec.id     = next_id_ff;
      birth_rec.cls    = cls_ff;
      birth_rec.pos    = pos_ff;
      birth_rec.vel    = dvel_ff;
      birth_rec.conf   = conf_ff;
      birth_rec.missed = '0;
      birth_rec.last   = now_ff;

      sweep_rec        = rd_ff;
      sweep_rec.missed = rd_ff.missed + 1'b1;

      if (commit_wr) begin
         we    = 1'b1;
         waddr = found_ff ? best_idx_ff : free_idx_ff;
         wdata = found_ff ? match_rec : birth_rec;
      end else begin
         we    = sweep_inc;
         waddr = p1_idx_ff;
         wdata = sweep_rec;
      end

      if (found_ff) begin
         res_in.track_id = hold_ff.id;
         res_in.cls      = hold_ff.cls;
         res_in.vel      = match_rec.vel;
         res_in.status   = gnntt_pkg::ST_UPDATED;
      end else if (free_found_ff) begin
         res_in.track_id = next_id_ff;
         res_in.cls      = cls_ff;
         res_in.vel      = dvel_ff;
         res_in.status   = gnntt_pkg::ST_BORN;
      end else begin
         res_in.track_id = '0;
         res_in.cls      = cls_ff;
         res_in.vel      = dvel_ff;
         res_in.status   = gnntt_pkg::ST_FULL;
      end
      res_in.pos   = pos_ff;
      res_in.conf  = conf_ff;
      res_in.stamp = now_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         next_id_ff   <= 32'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (sweep_drop) begin
            valid_ff[p1_idx_ff] <= 1'b0;
         end
         if (cmd.commit & ~found_ff & free_found_ff) begin
            valid_ff[free_idx_ff] <= 1'b1;
            // Ids skip zero when the counter wraps.
            next_id_ff <= (next_id_inc == 32'd0) ? 32'd1 : next_id_inc;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         res_ff <= res_in;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.track_id         = res_ff.track_id;
   assign rsp_ch.object_class_res = res_ff.cls;
   assign rsp_ch.pos_x_res        = res_ff.pos[0];
   assign rsp_ch.pos_y_res        = res_ff.pos[1];
   assign rsp_ch.pos_z_res        = res_ff.pos[2];
   assign rsp_ch.vel_x            = res_ff.vel[0];
   assign rsp_ch.vel_y            = res_ff.vel[1];
   assign rsp_ch.vel_z            = res_ff.vel[2];
   assign rsp_ch.confidence_res   = res_ff.conf;
   assign rsp_ch.stamp_us         = res_ff.stamp;
   assign rsp_ch.status           = res_ff.status;

   // Status toward the controller.
   always_comb begin
      stat.req_valid  = req_ch.valid;
      stat.go_sweep   = enable_ff & ((req_op == gnntt_pkg::OP_FRAME_BEGIN) |
                                     (req_op == gnntt_pkg::OP_FRAME_END));
      stat.go_scan    = enable_ff & (req_op == gnntt_pkg::OP_DETECT);
      stat.sweep_done = (cnt_ff == CW'(MAX_TRACKS)) & ~p1_vld_ff;
      stat.scan_done  = (cnt_ff == CW'(MAX_TRACKS)) & ~p1_vld_ff & ~p2_vld_ff;
      stat.found      = found_ff;
      stat.div_done   = &div_done;
      stat.out_free   = ~rsp_valid_ff | rsp_ch.ready;
   end
endmodule

FILE: src/gnntt_ctrl.sv
// Controller state machine that sequences sweeps, scans and the velocity update.
module gnntt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  gnntt_pkg::stat_type stat,
   output gnntt_pkg::cmd_type  cmd
);
   typedef enum logic [10:0] {
      S_IDLE     = 11'b00000000001,
      S_SWEEP    = 11'b00000000010,
      S_SCAN     = 11'b00000000100,
      S_FETCH    = 11'b00000001000,
      S_DIFF     = 11'b00000010000,
      S_MUL      = 11'b00000100000,
      S_DIV_GO   = 11'b00001000000,
      S_DIV_WAIT = 11'b00010000000,
      S_MIX      = 11'b00100000000,
      S_RECIP    = 11'b01000000000,
      S_COMMIT   = 11'b10000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.take = 1'b1;
            if (stat.req_valid) begin
               // Disabled or unknown beats are taken and dropped here.
               if (stat.go_sweep) begin
                  state_in = S_SWEEP;
               end else if (stat.go_scan) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_done) begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = stat.found ? S_FETCH : S_COMMIT;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            cmd.div_go = 1'b1;
            state_in   = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (stat.div_done) begin
               state_in = S_MIX;
            end
         end
         S_MIX: begin
            cmd.mix  = 1'b1;
            state_in = S_RECIP;
         end
         S_RECIP: begin
            cmd.recip = 1'b1;
            state_in  = S_COMMIT;
         end
         S_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

FILE: src/gated_nn_track_table_core.sv
// Frame sweeps walk all slots, one read-modify-write of the slot memory per cycle. A detection
// scans every slot; a match then runs fetch, difference, multiply, the 49-step restoring dividers
// (one per axis, in parallel), mix and reciprocal; a birth or full table ends after the scan.
// One item is in work at a time; the next beat is taken while a result waits in the output register.
// Reset is synchronous: all slots invalid, next id 1, registers back to their defaults.
module gated_nn_track_table_core #(
   parameter int MAX_TRACKS = 64
) (
   input  logic         clock,
   input  logic         reset,
   gnntt_req_if.sink    req_ch,
   gnntt_rsp_if.source  rsp_ch,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [3:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   gnntt_pkg::cmd_type  cmd;
   gnntt_pkg::stat_type stat;

   gnntt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   gnntt_dp #(
      .MAX_TRACKS(MAX_TRACKS)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cmd     (cmd),
      .stat    (stat)
   );
endmodule

FILE: tb/testbench.sv
// Self-checking testbench of the gated nearest-neighbor track table core.
module testbench;
   import gnntt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int Tracks   = 64;
   localparam int IdleMax  = 4000;
   localparam int SettleCy = 200;

   typedef struct {
      op_type                 op;
      logic [7:0]             cls;
      logic [2:0][CoordW-1:0] pos;
      logic [2:0][CoordW-1:0] dvel;
      logic [15:0]            conf;
      logic [TimeW-1:0]       stamp;
      bit                     drain;
   } det_item;

   logic        clock;
   logic        reset;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   gnntt_req_if req_bus();
   gnntt_rsp_if rsp_bus();

   gated_nn_track_table_core #(.MAX_TRACKS(Tracks)) u_dut (
      .clock(clock), .reset(reset), .req_ch(req_bus.sink), .rsp_ch(rsp_bus.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Predicted track table and registers.
   bit                      trk_valid [Tracks];
   logic [31:0]             trk_id    [Tracks];
   logic [7:0]              trk_cls   [Tracks];
   logic signed [23:0]      trk_pos   [Tracks][3];
   logic signed [23:0]      trk_vel   [Tracks][3];
   logic [15:0]             trk_conf  [Tracks];
   logic [MissW-1:0]        trk_miss  [Tracks];
   logic [TimeW-1:0]        trk_last  [Tracks];
   logic [31:0]             next_track_id = 32'd1;
   logic [19:0]             gate_mm = GATE_RESET;
   logic [15:0]             miss_limit = LIMIT_RESET;
   bit                      tracking_on = 1'b0;

   det_item  pending_items[$];
   res_type  track_results_due[$];
   det_item  cur_item;
   int       gap_left = 0;
   int       hold_left = 0;
   int       results_seen = 0;
   bit       long_hold_done = 1'b0;
   bit       quiet = 1'b0;
   int       error_count = 0;
   int       idle_cycles = 0;
   logic [TimeW-1:0] frame_us = '0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint div_near(longint n, longint unsigned dv, longint unsigned lim);
      longint unsigned mag, q;
      mag = (n < 0) ? longint'(-n) : n;
      q = (mag + dv / 2) / dv;
      if (q > lim) q = lim;
      return (n < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [23:0] vel_blend(logic signed [23:0] v, longint d,
                                                    longint unsigned e);
      longint inst, r;
      inst = div_near(d * 1000000, e, 64'd1 << 30);
      r = div_near(7 * longint'(v) + 3 * inst, 10, 64'd1 << 30);
      if (r > 8388607) r = 8388607;
      if (r < -8388608) r = -8388608;
      return r[23:0];
   endfunction

   function automatic void track_step(det_item it);
      int best, free_slot;
      longint unsigned bestd, d2, gate2, e;
      longint dl;
      res_type r;
      best = -1;
      free_slot = -1;
      bestd = 0;
      if (!tracking_on) return;
      case (it.op)
         OP_FRAME_BEGIN: begin
            for (int i = 0; i < Tracks; i++)
               if (trk_valid[i] && trk_miss[i] != MISS_MAX) trk_miss[i]++;
            return;
         end
         OP_FRAME_END: begin
            for (int i = 0; i < Tracks; i++)
               if (trk_valid[i] && trk_miss[i] > miss_limit) trk_valid[i] = 1'b0;
            return;
         end
         OP_DETECT: ;
         default: return;
      endcase
      gate2 = longint'(gate_mm) * longint'(gate_mm);
      for (int i = 0; i < Tracks; i++) begin
         if (!trk_valid[i]) begin
            if (free_slot < 0) free_slot = i;
            continue;
         end
         if (trk_cls[i] != it.cls) continue;
         d2 = 0;
         for (int k = 0; k < 3; k++) begin
            dl = longint'($signed(it.pos[k])) - longint'(trk_pos[i][k]);
            d2 += dl * dl;
         end
         if (d2 >= gate2) continue;
         if (best < 0 || d2 < bestd || (d2 == bestd && trk_id[i] < trk_id[best])) begin
            best = i;
            bestd = d2;
         end
      end
      r.stamp = it.stamp;
      r.conf = it.conf;
      if (best >= 0) begin
         if (it.stamp > trk_last[best]) begin
            e = it.stamp - trk_last[best];
            for (int k = 0; k < 3; k++)
               trk_vel[best][k] = vel_blend(trk_vel[best][k],
                  longint'($signed(it.pos[k])) - longint'(trk_pos[best][k]), e);
         end
         for (int k = 0; k < 3; k++) trk_pos[best][k] = it.pos[k];
         trk_conf[best] = it.conf;
         trk_miss[best] = '0;
         trk_last[best] = it.stamp;
         r.track_id = trk_id[best];
         r.cls = trk_cls[best];
         for (int k = 0; k < 3; k++) begin
            r.pos[k] = trk_pos[best][k];
            r.vel[k] = trk_vel[best][k];
         end
         r.status = ST_UPDATED;
      end else if (free_slot < 0) begin
         r.track_id = '0;
         r.cls = it.cls;
         r.pos = it.pos;
         r.vel = it.dvel;
         r.status = ST_FULL;
      end else begin
         trk_valid[free_slot] = 1'b1;
         trk_id[free_slot] = next_track_id;
         next_track_id++;
         if (next_track_id == 0) next_track_id = 32'd1;
         trk_cls[free_slot] = it.cls;
         for (int k = 0; k < 3; k++) begin
            trk_pos[free_slot][k] = it.pos[k];
            trk_vel[free_slot][k] = it.dvel[k];
         end
         trk_conf[free_slot] = it.conf;
         trk_miss[free_slot] = '0;
         trk_last[free_slot] = it.stamp;
         r.track_id = trk_id[free_slot];
         r.cls = it.cls;
         r.pos = it.pos;
         r.vel = it.dvel;
         r.status = ST_BORN;
      end
      track_results_due.push_back(r);
   endfunction

   function automatic int draw_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (quiet || pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Driver: one beat offered at a time, valid held until the beat is taken.
   always @(posedge clock) begin
      bit offering, next_valid;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) track_step(cur_item);
         offering = req_bus.valid && !req_bus.ready;
         next_valid = offering;
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() > 0 &&
                         !(pending_items[0].drain && track_results_due.size() > 0)) begin
               cur_item = pending_items.pop_front();
               req_bus.op <= cur_item.op;
               req_bus.object_class <= cur_item.cls;
               req_bus.pos_x <= cur_item.pos[0];
               req_bus.pos_y <= cur_item.pos[1];
               req_bus.pos_z <= cur_item.pos[2];
               req_bus.det_vel_x <= cur_item.dvel[0];
               req_bus.det_vel_y <= cur_item.dvel[1];
               req_bus.det_vel_z <= cur_item.dvel[2];
               req_bus.confidence <= cur_item.conf;
               req_bus.frame_time_us <= cur_item.stamp;
               next_valid = 1'b1;
               gap_left = draw_gap();
            end
         end
         req_bus.valid <= next_valid;
      end
   end

   // Monitor: checks each result beat against the oldest prediction.
   always @(posedge clock) begin
      res_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (track_results_due.size() == 0) begin
               report_mismatch("unexpected result, track_id", rsp_bus.track_id, 0);
            end else begin
               want = track_results_due.pop_front();
               if (rsp_bus.track_id !== want.track_id)
                  report_mismatch("track_id", rsp_bus.track_id, want.track_id);
               if (rsp_bus.object_class_res !== want.cls)
                  report_mismatch("object_class_res", rsp_bus.object_class_res, want.cls);
               if (rsp_bus.pos_x_res !== want.pos[0])
                  report_mismatch("pos_x_res", rsp_bus.pos_x_res, want.pos[0]);
               if (rsp_bus.pos_y_res !== want.pos[1])
                  report_mismatch("pos_y_res", rsp_bus.pos_y_res, want.pos[1]);
               if (rsp_bus.pos_z_res !== want.pos[2])
                  report_mismatch("pos_z_res", rsp_bus.pos_z_res, want.pos[2]);
               if (rsp_bus.vel_x !== want.vel[0])
                  report_mismatch("vel_x", rsp_bus.vel_x, want.vel[0]);
               if (rsp_bus.vel_y !== want.vel[1])
                  report_mismatch("vel_y", rsp_bus.vel_y, want.vel[1]);
               if (rsp_bus.vel_z !== want.vel[2])
                  report_mismatch("vel_z", rsp_bus.vel_z, want.vel[2]);
               if (rsp_bus.confidence_res !== want.conf)
                  report_mismatch("confidence_res", rsp_bus.confidence_res, want.conf);
               if (rsp_bus.stamp_us !== want.stamp)
                  report_mismatch("stamp_us", rsp_bus.stamp_us, want.stamp);
               if (rsp_bus.status !== want.status)
                  report_mismatch("status", rsp_bus.status, want.status);
            end
         end
         // One long hold-off lets the block fill up and stall its input.
         if (results_seen == 150 && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = 700;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            hold_left = draw_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || psel)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles == IdleMax) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic csr_write(reg_index_type idx, logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_GATE:   gate_mm = val[19:0];
         REG_LIMIT:  miss_limit = val[15:0];
         REG_ENABLE: tracking_on = val[0];
         default: ;
      endcase
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_items.size() > 0 || req_bus.valid || track_results_due.size() > 0)
         @(posedge clock);
      repeat (SettleCy) @(posedge clock);
   endtask

   function automatic det_item marker(op_type op);
      det_item it;
      it.op = op;
      it.cls = $urandom;
      for (int k = 0; k < 3; k++) begin
         it.pos[k] = $urandom;
         it.dvel[k] = $urandom;
      end
      it.conf = $urandom;
      it.stamp = frame_us;
      it.drain = 1'b0;
      return it;
   endfunction

   function automatic det_item detection(int spread);
      det_item it;
      int live[$];
      int j;
      it = marker(OP_DETECT);
      for (int i = 0; i < Tracks; i++) if (trk_valid[i]) live.push_back(i);
      if (live.size() > 0 && $urandom_range(0, 99) < 70) begin
         j = live[$urandom_range(0, live.size() - 1)];
         it.cls = trk_cls[j];
         for (int k = 0; k < 3; k++)
            it.pos[k] = 24'(int'(trk_pos[j][k]) + $signed($urandom_range(0, 2 * spread)) - spread);
      end else begin
         if ($urandom_range(0, 9) != 0) it.cls = $urandom_range(0, 3);
         if ($urandom_range(0, 4) != 0)
            for (int k = 0; k < 3; k++) it.pos[k] = 24'($signed($urandom_range(0, 100000)) - 50000);
      end
      return it;
   endfunction

   task automatic push_frames(int frames, int spread);
      int pick;
      for (int f = 0; f < frames; f++) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) frame_us = {$urandom, $urandom};
         else if (pick < 15) frame_us = frame_us;
         else if (pick < 25) frame_us = frame_us + 1;
         else frame_us = frame_us + $urandom_range(1, 200000);
         pending_items.push_back(marker(OP_FRAME_BEGIN));
         for (int n = $urandom_range(1, 8); n > 0; n--) begin
            pending_items.push_back(detection(spread));
            if ($urandom_range(0, 49) == 0) pending_items.push_back(marker(OP_UNUSED));
         end
         pending_items.push_back(marker(OP_FRAME_END));
      end
   endtask

   task automatic push_det(logic [7:0] cls, int x, int y, int z, logic [15:0] conf,
                           logic [TimeW-1:0] t);
      det_item it;
      it = marker(OP_DETECT);
      it.cls = cls;
      it.pos[0] = x[23:0];
      it.pos[1] = y[23:0];
      it.pos[2] = z[23:0];
      it.conf = conf;
      it.stamp = t;
      pending_items.push_back(it);
   endtask

   initial begin
      det_item it;
      req_bus.valid = 1'b0;
      req_bus.op = OP_FRAME_BEGIN;
      req_bus.object_class = '0;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.pos_z = '0;
      req_bus.det_vel_x = '0;
      req_bus.det_vel_y = '0;
      req_bus.det_vel_z = '0;
      req_bus.confidence = '0;
      req_bus.frame_time_us = '0;
      rsp_bus.ready = 1'b0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Disabled: every beat is dropped without a result.
      pending_items.push_back(marker(OP_FRAME_BEGIN));
      pending_items.push_back(detection(100));
      pending_items.push_back(marker(OP_FRAME_END));
      wait_idle();
      csr_write(REG_NONE, 32'hFFFF_FFFF);
      csr_write(REG_ENABLE, 32'd1);

      // Directed: field extremes, a match without elapsed time, a tie, unknown op.
      quiet = 1'b1;
      pending_items.push_back(marker(OP_FRAME_BEGIN));
      it = marker(OP_DETECT);
      it.cls = 8'd0;
      it.pos = '0;
      it.dvel = {3{24'h7FFFFF}};
      it.conf = 16'h0000;
      it.stamp = '0;
      pending_items.push_back(it);
      it.cls = 8'hFF;
      it.pos = {3{24'h7FFFFF}};
      it.dvel = {3{24'h800000}};
      it.conf = 16'hFFFF;
      pending_items.push_back(it);
      push_det(8'd0, -8388608, -8388608, -8388608, 16'h1234, 48'd0);
      push_det(8'd0, 100, 0, 0, 16'h5555, 48'd0);
      pending_items.push_back(marker(OP_FRAME_END));
      pending_items.push_back(marker(OP_FRAME_BEGIN));
      push_det(8'd0, 1100, -30, 7, 16'hAAAA, 48'd1000);
      push_det(8'd7, 1900, 0, 0, 16'd1, 48'd1000);
      push_det(8'd7, -1900, 0, 0, 16'd2, 48'd1000);
      push_det(8'd7, 0, 0, 0, 16'd3, 48'd1001);
      pending_items.push_back(marker(OP_UNUSED));
      push_det(8'hFF, 8388000, 8388607, 8388607, 16'd9, 48'hFFFF_FFFF_FFFF);
      push_det(8'd0, 5000, 0, 0, 16'd4, 48'd1002);
      pending_items.push_back(marker(OP_FRAME_END));
      wait_idle();
      quiet = 1'b0;

      // Default gate; one beat waits until every result has come.
      frame_us = 48'd5000;
      push_frames(60, 1500);
      it = marker(OP_FRAME_BEGIN);
      it.drain = 1'b1;
      pending_items.push_back(it);
      push_frames(60, 1500);
      wait_idle();

      // Zero gate and no deaths: the table fills up and overflows.
      csr_write(REG_GATE, 32'd0);
      csr_write(REG_LIMIT, 32'd65535);
      push_frames(20, 500);
      wait_idle();
      csr_write(REG_LIMIT, 32'd0);
      pending_items.push_back(marker(OP_FRAME_BEGIN));
      pending_items.push_back(marker(OP_FRAME_END));
      wait_idle();

      // Widest gate, short memory.
      csr_write(REG_GATE, 32'hFFFFF);
      csr_write(REG_LIMIT, 32'd2);
      push_frames(50, 40000);
      wait_idle();

      // Narrow gate, without idling.
      quiet = 1'b1;
      csr_write(REG_GATE, 32'd300);
      csr_write(REG_LIMIT, 32'd1);
      push_frames(50, 250);
      wait_idle();
      quiet = 1'b0;
      csr_write(REG_GATE, 32'd2000);
      csr_write(REG_LIMIT, 32'd3);
      push_frames(40, 1500);
      wait_idle();

      csr_write(REG_ENABLE, 32'd0);
      push_frames(2, 1500);
      wait_idle();

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
